// ----- hw/rtl/rgce_pkg.sv -----
// Shared types, constants and the microcode table of the reversible gate CNF encoder.
`default_nettype none

package rgce_pkg;

  // Sizing of the circuit and of the variable space.
  localparam int unsigned MAX_WIRES = 64;
  localparam int unsigned VAR_BITS  = 20;

  // Fixed field widths.
  localparam int unsigned WIRE_W = 6;
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned NV_W   = VAR_BITS + 1;
  localparam int unsigned LIT_W  = 21;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned VT_W   = 20;
  localparam int unsigned CC_W   = 24;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned TV_W   = 64;
  localparam int unsigned STEP_W = 4;

  localparam logic [NV_W-1:0] VAR_LIMIT  = NV_W'((64'd1 << VAR_BITS) - 64'd1);
  localparam logic [NV_W-1:0] NV_RESET   = NV_W'(MAX_WIRES + 1);
  localparam logic [CC_W-1:0] CC_MAX     = {CC_W{1'b1}};
  localparam logic [CFG_W-1:0] WIRES_MAX = CFG_W'(MAX_WIRES);

  typedef enum logic [KIND_W-1:0] {
    KIND_BEGIN  = 2'd0,
    KIND_GATE   = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_WIRE_OOR = 2'd1,
    ST_VAR_OVF  = 2'd2,
    ST_BAD_CFG  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_WIRE_COUNT   = 2'd0,
    CFG_LEAD_ZEROS   = 2'd1,
    CFG_TARGET_COUNT = 2'd2,
    CFG_TARGET_VALUE = 2'd3
  } cfg_idx_e;

  // Microcode fields.
  typedef enum logic [2:0] {
    RD_NONE, RD_TGT, RD_OR, RD_INV, RD_IDX
  } rd_sel_e;

  typedef enum logic [1:0] {
    LD_NONE, LD_A, LD_B, LD_C
  } ld_sel_e;

  typedef enum logic [3:0] {
    PAT_NONE, PAT_EMPTY, PAT_UNIT,
    PAT_G0, PAT_G1, PAT_G2, PAT_G3, PAT_G4, PAT_G5
  } pat_e;

  typedef enum logic [1:0] {
    JMP_NEXT, JMP_DONE, JMP_IF_EMPTY, JMP_LOOP
  } jmp_e;

  typedef struct packed {
    rd_sel_e             rd;
    ld_sel_e             ld;
    pat_e                pat;
    logic                wr_map;
    logic                init;
    logic                idx_inc;
    jmp_e                jmp;
    logic [STEP_W-1:0]   tgt;
  } ucw_t;

  // Conditions fed back from the datapath to the sequencer.
  typedef struct packed {
    logic room;
    logic loop_empty;
    logic loop_final;
  } seq_cond_t;

  // Control handed from the sequencer to the datapath.
  typedef struct packed {
    logic fire;
    ucw_t cw;
  } seq_ctrl_t;

  // Program entry points and steps.
  localparam logic [STEP_W-1:0] S_EMPTY = 4'd0;
  localparam logic [STEP_W-1:0] S_BEGIN = 4'd1;
  localparam logic [STEP_W-1:0] S_CHK   = 4'd2;
  localparam logic [STEP_W-1:0] S_LRD   = 4'd3;
  localparam logic [STEP_W-1:0] S_LEM   = 4'd4;
  localparam logic [STEP_W-1:0] S_G0    = 4'd5;
  localparam logic [STEP_W-1:0] S_G1    = 4'd6;
  localparam logic [STEP_W-1:0] S_G2    = 4'd7;
  localparam logic [STEP_W-1:0] S_G3    = 4'd8;
  localparam logic [STEP_W-1:0] S_G4    = 4'd9;
  localparam logic [STEP_W-1:0] S_G5    = 4'd10;
  localparam logic [STEP_W-1:0] S_G6    = 4'd11;
  localparam logic [STEP_W-1:0] S_G7    = 4'd12;
  localparam logic [STEP_W-1:0] S_G8    = 4'd13;

  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    w = '{rd: RD_NONE, ld: LD_NONE, pat: PAT_NONE, wr_map: 1'b0, init: 1'b0,
          idx_inc: 1'b0, jmp: JMP_NEXT, tgt: S_EMPTY};
    unique case (step)
      S_EMPTY: begin w.pat = PAT_EMPTY; w.jmp = JMP_DONE; end
      S_BEGIN: w.init = 1'b1;
      S_CHK:   begin w.jmp = JMP_IF_EMPTY; w.tgt = S_EMPTY; end
      S_LRD:   w.rd = RD_IDX;
      S_LEM:   begin
        w.pat = PAT_UNIT; w.idx_inc = 1'b1; w.jmp = JMP_LOOP; w.tgt = S_LRD;
      end
      S_G0:    w.rd = RD_TGT;
      S_G1:    begin w.ld = LD_A; w.rd = RD_OR; end
      S_G2:    begin w.ld = LD_B; w.rd = RD_INV; end
      S_G3:    begin w.ld = LD_C; w.wr_map = 1'b1; w.pat = PAT_G0; end
      S_G4:    w.pat = PAT_G1;
      S_G5:    w.pat = PAT_G2;
      S_G6:    w.pat = PAT_G3;
      S_G7:    w.pat = PAT_G4;
      S_G8:    begin w.pat = PAT_G5; w.jmp = JMP_DONE; end
      default: w.jmp = JMP_DONE;
    endcase
    return w;
  endfunction

  // Signed literal from a variable number, masked to the literal width.
  function automatic logic [LIT_W-1:0] mk_lit(input logic [VAR_BITS-1:0] v,
                                              input logic neg);
    logic [LIT_W-1:0] m;
    m = LIT_W'(v);
    return neg ? (~m + LIT_W'(1)) : m;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rgce_wire_map.sv -----
// Wire-to-variable map: one write port, one registered read port, per-entry valid bits.
`default_nettype none

module rgce_wire_map (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              clear_i,
  input  logic                              we_i,
  input  logic [rgce_pkg::WIRE_W-1:0]       waddr_i,
  input  logic [rgce_pkg::VAR_BITS-1:0]     wdata_i,
  input  logic                              re_i,
  input  logic [rgce_pkg::WIRE_W-1:0]       raddr_i,
  output logic [rgce_pkg::VAR_BITS-1:0]     rdata_o
);
  import rgce_pkg::*;

  logic [VAR_BITS-1:0]  mem_q [MAX_WIRES];
  logic [MAX_WIRES-1:0] valid_q;
  logic [VAR_BITS-1:0]  rdata_q;

  // An entry never written since the last clear holds its own wire number plus one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i]
                                  : VAR_BITS'(raddr_i) + VAR_BITS'(1);
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rgce_sequencer.sv -----
// Microcode sequencer: step counter, program table lookup and jump logic.
`default_nettype none

module rgce_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rgce_pkg::STEP_W-1:0]   entry_i,
  input  rgce_pkg::seq_cond_t           cond_i,
  output rgce_pkg::seq_ctrl_t           ctrl_o,
  output logic                          busy_o
);
  import rgce_pkg::*;

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  ucw_t              cw;
  logic              fire;

  assign cw   = ucode(step_q);
  // A step that produces a result waits until the output register has room.
  assign fire = busy_q && !((cw.pat != PAT_NONE) && !cond_i.room);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = entry_i;
    end else if (fire) begin
      unique case (cw.jmp)
        JMP_NEXT:     step_d = step_q + STEP_W'(1);
        JMP_DONE:     busy_d = 1'b0;
        JMP_IF_EMPTY: step_d = cond_i.loop_empty ? cw.tgt : step_q + STEP_W'(1);
        JMP_LOOP: begin
          if (cond_i.loop_final) begin
            busy_d = 1'b0;
          end else begin
            step_d = cw.tgt;
          end
        end
        default:      busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= S_EMPTY;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  assign ctrl_o = '{fire: fire, cw: cw};
  assign busy_o = busy_q;

endmodule

`default_nettype wire

// ----- hw/rtl/reversible_gate_cnf_encoder.sv -----
// Top level of the reversible gate CNF encoder: ports, item decode, datapath and result register.
`default_nettype none

// Turns a stream of reversible-circuit items into CNF clauses, one clause per output
// transaction. A begin item resets the wire-to-variable map and emits a negative unit
// clause for each of the top leading_zero_count wires; a gate item (target ^= or OR NOT inv)
// allocates a fresh variable for the target wire and emits six clauses; a finish item emits
// one unit clause per low wire, fixing it to the matching bit of target_value. Items are
// handled one at a time by a small microcoded sequencer that drives this datapath. A gate
// item is taken, then makes three reads of the wire map's single read port, the third
// overlapped with the first clause, then one clause per cycle while the result side does
// not stall; a new item is only taken once the previous one is through. Each unit clause
// of begin and finish costs one map read and one result. A stall on the result side holds
// the sequencer at its next result step, except that the last result of an item may wait
// in the result register while the next item starts. Kind 3 is taken and dropped. No
// clearing pass runs after reset: the map keeps a valid bit per wire, so the block is
// ready at once.
// Configuration may only be written while the block is idle; the port is always ready.

module reversible_gate_cnf_encoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Configuration write channel.
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [63:0]   cfg_data_i,
  // Item input.
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [23:0]   s_axis_tdata,   // target_wire[5:0], or_wire[11:6], inv_wire[17:12]
  input  logic [1:0]    s_axis_tuser,   // kind[1:0]
  // Clause output.
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [135:0]  m_axis_tdata,   // lit_a[20:0], lit_b[41:21], lit_c[62:42],
                                        // lit_d[83:63], lit_count[86:84],
                                        // var_total[106:87], clause_total[130:107]
  output logic          m_axis_tlast,   // last
  output logic [1:0]    m_axis_tuser    // status[1:0]
);
  import rgce_pkg::*;

  // ------------------------------------------------------------------
  // Configuration registers.
  // ------------------------------------------------------------------
  logic [CFG_W-1:0] wc_q, lz_q, tc_q;
  logic [TV_W-1:0]  tv_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q <= WIRES_MAX;
      lz_q <= '0;
      tc_q <= '0;
      tv_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIRE_COUNT:   wc_q <= cfg_data_i[CFG_W-1:0];
        CFG_LEAD_ZEROS:   lz_q <= cfg_data_i[CFG_W-1:0];
        CFG_TARGET_COUNT: tc_q <= cfg_data_i[CFG_W-1:0];
        CFG_TARGET_VALUE: tv_q <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Item decode. All checks are made in the cycle the item is taken, so
  // the sequencer starts directly at the right part of the program.
  // ------------------------------------------------------------------
  kind_e             in_kind;
  logic [WIRE_W-1:0] in_tgt, in_or, in_inv;
  logic              in_accept, start, busy;
  logic              bad_cfg, wire_oor, var_ovf;
  logic [STEP_W-1:0] entry;
  status_e           entry_st;

  assign in_kind = kind_e'(s_axis_tuser);
  assign in_tgt  = s_axis_tdata[5:0];
  assign in_or   = s_axis_tdata[11:6];
  assign in_inv  = s_axis_tdata[17:12];

  assign s_axis_tready = !busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign start         = in_accept && (in_kind != KIND_NONE);

  // Sequencer state lives in the rgce_sequencer instance; these are the datapath registers.
  logic [NV_W-1:0]     nv_q, nv_d;
  logic [CC_W-1:0]     cc_q, cc_d;
  logic [WIRE_W-1:0]   t_q, o_q, v_q;
  logic [VAR_BITS-1:0] n_q, a_q, b_q, c_q;
  logic [CFG_W-1:0]    idx_q, end_q;
  kind_e               kind_q;
  status_e             st_q;

  assign bad_cfg  = (wc_q == '0) || (wc_q > WIRES_MAX) || (lz_q > wc_q) || (tc_q > wc_q);
  assign wire_oor = ({1'b0, in_tgt} >= wc_q) || ({1'b0, in_or} >= wc_q) ||
                    ({1'b0, in_inv} >= wc_q);
  assign var_ovf  = nv_q > VAR_LIMIT;

  always_comb begin
    entry    = S_EMPTY;
    entry_st = ST_OK;
    if (bad_cfg) begin
      entry_st = ST_BAD_CFG;
    end else begin
      unique case (in_kind)
        KIND_BEGIN:  entry = S_BEGIN;
        KIND_FINISH: entry = S_CHK;
        KIND_GATE: begin
          priority if (wire_oor) begin
            entry_st = ST_WIRE_OOR;
          end else if (var_ovf) begin
            entry_st = ST_VAR_OVF;
          end else begin
            entry = S_G0;
          end
        end
        default:     entry = S_EMPTY;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Sequencer and wire map.
  // ------------------------------------------------------------------
  seq_ctrl_t           ctrl;
  seq_cond_t           cond;
  logic                out_valid_q;
  logic                room;
  logic [WIRE_W-1:0]   raddr;
  logic [VAR_BITS-1:0] rdata;
  logic                loop_final;

  assign room       = !out_valid_q || m_axis_tready;
  assign loop_final = (idx_q + CFG_W'(1)) == end_q;
  assign cond       = '{room: room, loop_empty: (idx_q == end_q), loop_final: loop_final};

  rgce_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .entry_i (entry),
    .cond_i  (cond),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  always_comb begin
    unique case (ctrl.cw.rd)
      RD_OR:   raddr = o_q;
      RD_INV:  raddr = v_q;
      RD_IDX:  raddr = idx_q[WIRE_W-1:0];
      default: raddr = t_q;
    endcase
  end

  rgce_wire_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (ctrl.fire && ctrl.cw.init),
    .we_i    (ctrl.fire && ctrl.cw.wr_map),
    .waddr_i (t_q),
    .wdata_i (n_q),
    .re_i    (ctrl.fire && (ctrl.cw.rd != RD_NONE)),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // ------------------------------------------------------------------
  // Item registers, loaded when the item is taken. The unit-clause loop runs
  // idx from its start up to but not including end.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (start) begin
      kind_q <= in_kind;
      st_q   <= entry_st;
      t_q    <= in_tgt;
      o_q    <= in_or;
      v_q    <= in_inv;
      n_q    <= nv_q[VAR_BITS-1:0];
      if (in_kind == KIND_BEGIN) begin
        idx_q <= wc_q - lz_q;
        end_q <= wc_q;
      end else begin
        idx_q <= '0;
        end_q <= tc_q;
      end
    end else if (ctrl.fire && ctrl.cw.idx_inc) begin
      idx_q <= idx_q + CFG_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.fire) begin
      unique case (ctrl.cw.ld)
        LD_A:    a_q <= rdata;
        LD_B:    b_q <= rdata;
        LD_C:    c_q <= rdata;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Clause formation.
  // ------------------------------------------------------------------
  logic                emit, emit_clause;
  logic [LIT_W-1:0]    lit0_d, lit1_d, lit2_d, lit3_d;
  logic [CNT_W-1:0]    cnt_d;
  logic                last_d;
  logic [VT_W-1:0]     vt_d;
  logic [CC_W-1:0]     cc_inc;
  logic                unit_pos;

  assign emit        = ctrl.fire && (ctrl.cw.pat != PAT_NONE);
  assign emit_clause = emit && (ctrl.cw.pat != PAT_EMPTY);
  assign cc_inc      = (cc_q == CC_MAX) ? cc_q : cc_q + CC_W'(1);
  assign unit_pos    = (kind_q == KIND_FINISH) && tv_q[idx_q[WIRE_W-1:0]];

  always_comb begin
    lit0_d = '0;
    lit1_d = '0;
    lit2_d = '0;
    lit3_d = '0;
    cnt_d  = CNT_W'(3);
    last_d = 1'b0;
    // A gate result already shows its freshly allocated variable.
    vt_d   = VT_W'(n_q);
    unique case (ctrl.cw.pat)
      PAT_UNIT: begin
        lit0_d = mk_lit(rdata, !unit_pos);
        cnt_d  = CNT_W'(1);
        last_d = loop_final;
        vt_d   = VT_W'(nv_q - NV_W'(1));
      end
      PAT_G0: begin
        lit0_d = mk_lit(a_q, 1'b1);
        lit1_d = mk_lit(b_q, 1'b1);
        lit2_d = mk_lit(n_q, 1'b1);
      end
      PAT_G1: begin
        lit0_d = mk_lit(a_q, 1'b1);
        lit1_d = mk_lit(c_q, 1'b0);
        lit2_d = mk_lit(n_q, 1'b1);
      end
      PAT_G2: begin
        lit0_d = mk_lit(a_q, 1'b0);
        lit1_d = mk_lit(b_q, 1'b1);
        lit2_d = mk_lit(n_q, 1'b0);
      end
      PAT_G3: begin
        lit0_d = mk_lit(a_q, 1'b0);
        lit1_d = mk_lit(c_q, 1'b0);
        lit2_d = mk_lit(n_q, 1'b0);
      end
      PAT_G4: begin
        lit0_d = mk_lit(a_q, 1'b1);
        lit1_d = mk_lit(b_q, 1'b0);
        lit2_d = mk_lit(c_q, 1'b1);
        lit3_d = mk_lit(n_q, 1'b0);
        cnt_d  = CNT_W'(4);
      end
      PAT_G5: begin
        lit0_d = mk_lit(a_q, 1'b0);
        lit1_d = mk_lit(b_q, 1'b0);
        lit2_d = mk_lit(c_q, 1'b1);
        lit3_d = mk_lit(n_q, 1'b1);
        cnt_d  = CNT_W'(4);
        last_d = 1'b1;
      end
      default: begin
        // Empty result: no literals, current totals.
        cnt_d  = '0;
        last_d = 1'b1;
        vt_d   = VT_W'(nv_q - NV_W'(1));
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Variable and clause counters.
  // ------------------------------------------------------------------
  always_comb begin
    nv_d = nv_q;
    cc_d = cc_q;
    if (ctrl.fire && ctrl.cw.init) begin
      nv_d = NV_W'(wc_q) + NV_W'(1);
      cc_d = '0;
    end else begin
      if (ctrl.fire && ctrl.cw.wr_map) begin
        nv_d = nv_q + NV_W'(1);
      end
      if (emit_clause) begin
        cc_d = cc_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= NV_RESET;
      cc_q <= '0;
    end else begin
      nv_q <= nv_d;
      cc_q <= cc_d;
    end
  end

  // ------------------------------------------------------------------
  // Result register.
  // ------------------------------------------------------------------
  logic [LIT_W-1:0] out_lit0_q, out_lit1_q, out_lit2_q, out_lit3_q;
  logic [CNT_W-1:0] out_cnt_q;
  logic             out_last_q;
  status_e          out_st_q;
  logic [VT_W-1:0]  out_vt_q;
  logic [CC_W-1:0]  out_cc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_lit0_q <= lit0_d;
      out_lit1_q <= lit1_d;
      out_lit2_q <= lit2_d;
      out_lit3_q <= lit3_d;
      out_cnt_q  <= cnt_d;
      out_last_q <= last_d;
      out_st_q   <= (ctrl.cw.pat == PAT_EMPTY) ? st_q : ST_OK;
      out_vt_q   <= vt_d;
      out_cc_q   <= emit_clause ? cc_inc : cc_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_cc_q, out_vt_q, out_cnt_q,
                          out_lit3_q, out_lit2_q, out_lit1_q, out_lit0_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_st_q;

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------

  // A result step only advances when the result register can take it.
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> room)
    else $error("result produced while the result register was full");

  // The variable counter only moves backwards when a begin item restarts it.
  a_nv_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.fire && ctrl.cw.init) |=> nv_q >= $past(nv_q))
    else $error("variable counter went backwards outside a begin item");

  // An error result never carries literals.
  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_st_q != ST_OK)) |-> (out_cnt_q == '0) && out_last_q)
    else $error("error result carries literals or is not the last of its item");

  // An accepted item always sets the sequencer busy.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy)
    else $error("sequencer did not start on an accepted item");

endmodule

`default_nettype wire
